### rtl/lap3_pkg.sv
package lap3_pkg;

   localparam int PIXEL_W      = 8;
   localparam int EDGE_W       = 11;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int ROW_W        = 12;
   localparam int N_CELLS      = 2;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MIN   = 13'd3;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // one window column, top row oldest
   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] bot;
   } column_type;

   // one line buffer entry holding both stored rows at a column
   typedef struct packed {
      logic [PIXEL_W-1:0] two_above;
      logic [PIXEL_W-1:0] above;
   } line_pair_type;

endpackage

### rtl/lap3_req_if.sv
interface lap3_req_if;
   logic                         valid;
   logic                         ready;
   logic [lap3_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

### rtl/lap3_rsp_if.sv
interface lap3_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [lap3_pkg::EDGE_W-1:0] edge_value;
   logic                               row_last;
   logic                               frame_last;

   modport source (output valid, output edge_value, output row_last, output frame_last,
                   input ready);
   modport sink   (input valid, input edge_value, input row_last, input frame_last,
                   output ready);
endinterface

### rtl/lap3_linebuf.sv
module lap3_linebuf #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   output lap3_pkg::line_pair_type rd_data,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  lap3_pkg::line_pair_type wr_data
);

   lap3_pkg::line_pair_type mem [DEPTH];
   lap3_pkg::line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lap3_cell.sv
module lap3_cell (
   input  logic                 clock,
   input  logic                 shift_en,
   input  lap3_pkg::column_type col_in,
   output lap3_pkg::column_type col_out
);

   lap3_pkg::column_type col_ff;

   // takes the neighbor column on every window shift
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

### rtl/laplacian_3x3_filter.sv
// Streaming 3x3 Laplacian (four-neighbor kernel: 4*center minus up, down, left and right).
// Pixels arrive in raster order on req_channel, one transaction per pixel, for a frame of
// image_width x image_height (csr index 0 and 1, saturated to 3..MAX_WIDTH and 3..4096).
// Each interior pixel yields one rsp_channel transaction with a signed 11-bit edge_value and
// row_last/frame_last flags; the first two rows and first two columns of every row give no
// result. The block sustains one pixel per clock while the result channel is not stalled: each
// taken pixel has the line buffer memory read at its column, the pixel before is written back
// at its own column, and the window chain shifts by one column.
// A result enters the output register when its pixel leaves stage 1. Any csr write restarts
// the frame position at row 0, column 0; write only while the block is idle.
// Line buffer contents are not cleared at reset, so no clearing pass is needed.
module laplacian_3x3_filter #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   lap3_req_if.sink                            req_channel,
   lap3_rsp_if.source                          rsp_channel,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [lap3_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [13:0] MAX_WIDTH_14 = 14'(MAX_WIDTH);

   // saturated width minus one, i.e. the last column index
   function automatic logic [COL_W-1:0] last_col_of(input logic [lap3_pkg::CFG_WIDTH_W-1:0] w);
      logic [13:0] wx;
      wx = {3'b000, w};
      if (wx < 14'd3) begin
         wx = 14'd3;
      end else if (wx > MAX_WIDTH_14) begin
         wx = MAX_WIDTH_14;
      end
      return COL_W'(wx - 14'd1);
   endfunction

   function automatic logic [lap3_pkg::ROW_W-1:0] last_row_of(
      input logic [lap3_pkg::CFG_HEIGHT_W-1:0] h);
      logic [lap3_pkg::CFG_HEIGHT_W-1:0] hx;
      hx = h;
      if (hx < lap3_pkg::HEIGHT_MIN) begin
         hx = lap3_pkg::HEIGHT_MIN;
      end else if (hx > lap3_pkg::HEIGHT_LIMIT) begin
         hx = lap3_pkg::HEIGHT_LIMIT;
      end
      return lap3_pkg::ROW_W'(hx - 13'd1);
   endfunction

   // frame geometry, kept as last indexes
   logic [COL_W-1:0]              last_col_ff;
   logic [lap3_pkg::ROW_W-1:0]    last_row_ff;

   // position of the next pixel
   logic [COL_W-1:0]              col_ff, col_in;
   logic [lap3_pkg::ROW_W-1:0]    row_ff, row_in;

   // stage 1: pixel waiting for its line buffer read data
   logic                          s1_valid_ff, s1_valid_in;
   logic [lap3_pkg::PIXEL_W-1:0]  s1_px_ff;
   logic [COL_W-1:0]              s1_col_ff;
   logic                          s1_produce_ff;
   logic                          s1_row_last_ff;
   logic                          s1_frame_last_ff;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [lap3_pkg::EDGE_W-1:0] rsp_edge_ff;
   logic                               rsp_row_last_ff;
   logic                               rsp_frame_last_ff;

   logic                          req_accept;
   logic                          out_free;
   logic                          s1_advance;
   logic                          col_at_end;
   logic                          row_at_end;

   lap3_pkg::line_pair_type       lb_rd;
   lap3_pkg::line_pair_type       lb_wr;
   lap3_pkg::column_type          new_col;
   lap3_pkg::column_type          cell_in  [lap3_pkg::N_CELLS];
   lap3_pkg::column_type          cell_out [lap3_pkg::N_CELLS];
   logic signed [lap3_pkg::EDGE_W-1:0] edge_sum;

   // handshake and pipeline flow
   assign out_free    = !rsp_valid_ff || rsp_channel.ready;
   assign s1_advance  = s1_valid_ff && (!s1_produce_ff || out_free);
   assign req_channel.ready = !s1_valid_ff || s1_advance;
   assign req_accept  = req_channel.valid && req_channel.ready;

   assign col_at_end  = (col_ff == last_col_ff);
   assign row_at_end  = (row_ff == last_row_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= last_col_of(lap3_pkg::WIDTH_RESET);
         last_row_ff <= last_row_of(lap3_pkg::HEIGHT_RESET);
      end else if (csr_write_enable) begin
         unique case (lap3_pkg::reg_index_type'(csr_index))
            lap3_pkg::REG_IMAGE_WIDTH: begin
               last_col_ff <= last_col_of(csr_data[lap3_pkg::CFG_WIDTH_W-1:0]);
            end
            lap3_pkg::REG_IMAGE_HEIGHT: begin
               last_row_ff <= last_row_of(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   // raster position, restarted by any csr write
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write_enable) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_at_end) begin
            col_in = '0;
            row_in = row_at_end ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1 register
   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_px_ff         <= req_channel.pixel;
         s1_col_ff        <= col_ff;
         s1_produce_ff    <= (row_ff >= 12'd2) && (col_ff >= COL_W'(2));
         s1_row_last_ff   <= col_at_end;
         s1_frame_last_ff <= col_at_end && row_at_end;
      end
   end

   // line buffers: read at accept, write back the shifted pair when stage 1 moves on
   assign lb_wr.two_above = lb_rd.above;
   assign lb_wr.above     = s1_px_ff;

   lap3_linebuf #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_linebuf (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (lb_rd),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (lb_wr)
   );

   // window chain: the newest column enters the last cell and moves toward cell 0
   assign new_col.top = lb_rd.two_above;
   assign new_col.mid = lb_rd.above;
   assign new_col.bot = s1_px_ff;

   for (genvar i = 0; i < lap3_pkg::N_CELLS; i++) begin : g_cells
      if (i == lap3_pkg::N_CELLS - 1) begin : g_head
         assign cell_in[i] = new_col;
      end else begin : g_link
         assign cell_in[i] = cell_out[i+1];
      end

      lap3_cell u_cell (
         .clock    (clock),
         .shift_en (s1_advance),
         .col_in   (cell_in[i]),
         .col_out  (cell_out[i])
      );
   end

   // before the shift the center column is the last cell, left is cell 0, right is new
   always_comb begin
      edge_sum = lap3_pkg::EDGE_W'({cell_out[1].mid, 2'b00})
               - lap3_pkg::EDGE_W'(cell_out[1].top)
               - lap3_pkg::EDGE_W'(cell_out[1].bot)
               - lap3_pkg::EDGE_W'(cell_out[0].mid)
               - lap3_pkg::EDGE_W'(new_col.mid);
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_produce_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_produce_ff) begin
         rsp_edge_ff       <= edge_sum;
         rsp_row_last_ff   <= s1_row_last_ff;
         rsp_frame_last_ff <= s1_frame_last_ff;
      end
   end

   assign rsp_channel.valid      = rsp_valid_ff;
   assign rsp_channel.edge_value = rsp_edge_ff;
   assign rsp_channel.row_last   = rsp_row_last_ff;
   assign rsp_channel.frame_last = rsp_frame_last_ff;

   // position stays inside the configured frame
   a_col_bound : assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col_ff)
      else $error("column position beyond last column");

   a_row_bound : assert property (@(posedge clock) disable iff (reset)
      row_ff <= last_row_ff)
      else $error("row position beyond last row");

   // the last pixel of a frame wraps the position to the origin
   a_frame_wrap : assert property (@(posedge clock) disable iff (reset)
      req_accept && !csr_write_enable && col_at_end && row_at_end |=>
         (col_ff == '0) && (row_ff == '0))
      else $error("frame did not wrap after its last pixel");

   // a frame end result is always a row end result
   a_frame_last_row : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_last_ff |-> rsp_row_last_ff)
      else $error("frame_last without row_last");

endmodule

### dv/laplacian_3x3_filter_tb.sv
`timescale 1ns / 100ps

module laplacian_3x3_filter_tb;

   localparam int MAX_WIDTH      = 1024;
   localparam int PIPE_LATENCY   = 1;     // pixel taken to result register
   localparam int SETTLE_CYCLES  = 16;
   localparam int ITEMS_PER_MODE = 150;

   // one transaction on the result channel
   typedef struct {
      logic signed [lap3_pkg::EDGE_W-1:0] edge_value;
      logic                               row_last;
      logic                               frame_last;
   } edge_result_type;

   // directed stimulus: a csr write, one pixel, or a burst of random pixels
   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_PIXEL,
      ROW_BURST
   } row_kind_type;

   typedef struct packed {
      row_kind_type                       kind;
      lap3_pkg::reg_index_type            csr_reg;
      logic [lap3_pkg::CSR_DATA_W-1:0]    csr_value;
      logic [lap3_pkg::PIXEL_W-1:0]       pixel;
      logic [12:0]                        burst_len;
      logic                               typed;       // expected result given in the row
      logic signed [lap3_pkg::EDGE_W-1:0] edge_value;
      logic                               row_last;
      logic                               frame_last;
   } stim_row_type;

   localparam stim_row_type DIRECTED [0:23] = '{
      // reset settings 640 x 480: part of the first row, no result expected
      '{ROW_BURST, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd0, 13'd40, 1'b0, 11'sd0, 1'b0, 1'b0},
      // width 0 and height 2 both saturate up to the 3 x 3 minimum
      '{ROW_CSR, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd0, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_CSR, lap3_pkg::REG_IMAGE_HEIGHT, 13'd2, 8'd0, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      // bright center on dark neighbors, corners carry no weight
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd17, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd0, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd34, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd0, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd255, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd0, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd51, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd0, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd68, 13'd0, 1'b1, 11'sd1020, 1'b1, 1'b1},
      // next frame follows without a write: dark center on bright neighbors
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd255, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd255, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd255, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd255, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd0, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd255, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd255, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd255, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd255, 13'd0, 1'b1, -11'sd1020, 1'b1,
        1'b1},
      // partial frame, then a write restarts the frame position
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd200, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_PIXEL, lap3_pkg::REG_IMAGE_WIDTH, 13'd0, 8'd100, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0},
      '{ROW_CSR, lap3_pkg::REG_IMAGE_HEIGHT, 13'd5, 8'd0, 13'd0, 1'b0, 11'sd0, 1'b0, 1'b0}
   };

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write_enable;
   logic                            csr_index;
   logic [lap3_pkg::CSR_DATA_W-1:0] csr_data;

   lap3_req_if req_bus ();
   lap3_rsp_if rsp_bus ();

   laplacian_3x3_filter #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // idle percentages, changed between stimulus modes
   int send_idle_pct;
   int recv_idle_pct;
   int error_count;

   // edge results still to come, oldest first
   edge_result_type pending_edges [$];

   // predictor state: two stored rows, 3 x 3 window, frame position, registers
   logic [lap3_pkg::PIXEL_W-1:0]      row_m1 [MAX_WIDTH];
   logic [lap3_pkg::PIXEL_W-1:0]      row_m2 [MAX_WIDTH];
   logic [lap3_pkg::PIXEL_W-1:0]      window_px [9];
   int                                next_col;
   int                                next_row;
   logic [lap3_pkg::CFG_WIDTH_W-1:0]  frame_width_reg;
   logic [lap3_pkg::CFG_HEIGHT_W-1:0] frame_height_reg;

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int active_width();
      return clamp_int(int'(frame_width_reg), 3, MAX_WIDTH);
   endfunction

   function automatic int active_height();
      return clamp_int(int'(frame_height_reg), 3, int'(lap3_pkg::HEIGHT_LIMIT));
   endfunction

   task automatic reset_laplacian();
      foreach (row_m1[i]) begin
         row_m1[i] = '0;
         row_m2[i] = '0;
      end
      foreach (window_px[i]) window_px[i] = '0;
      next_col         = 0;
      next_row         = 0;
      frame_width_reg  = lap3_pkg::WIDTH_RESET;
      frame_height_reg = lap3_pkg::HEIGHT_RESET;
   endtask

   // shifts the window by one column and works out the response at its center
   task automatic advance_laplacian(input logic [lap3_pkg::PIXEL_W-1:0] px,
                                    output bit has_result, output edge_result_type res);
      int w;
      int h;
      int acc;
      w = active_width();
      h = active_height();
      for (int k = 0; k < 3; k++) begin
         window_px[3*k]   = window_px[3*k+1];
         window_px[3*k+1] = window_px[3*k+2];
      end
      window_px[2] = row_m2[next_col];
      window_px[5] = row_m1[next_col];
      window_px[8] = px;
      // four times the center minus up, left, right and down
      acc = 4 * int'(window_px[4]) - int'(window_px[1]) - int'(window_px[3])
            - int'(window_px[5]) - int'(window_px[7]);
      has_result     = (next_row >= 2) && (next_col >= 2);
      res.edge_value = acc[lap3_pkg::EDGE_W-1:0];
      res.row_last   = (next_col == w - 1);
      res.frame_last = (next_col == w - 1) && (next_row == h - 1);
      row_m2[next_col] = row_m1[next_col];
      row_m1[next_col] = px;
      next_col++;
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
         if (next_row >= h) next_row = 0;
      end
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 32;
            recv_idle_pct = 86;
         end
         1: begin
            send_idle_pct = 86;
            recv_idle_pct = 32;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // hold off the sender until every expected result has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_edges.size() != 0);
   endtask

   // registers change only with the block idle; a pixel without a result
   // may still be in the pipeline, so wait on after the drain as well
   task automatic write_csr(input lap3_pkg::reg_index_type which,
                            input logic [lap3_pkg::CSR_DATA_W-1:0] value);
      drain_results();
      repeat (PIPE_LATENCY + 2) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_data         <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (which == lap3_pkg::REG_IMAGE_WIDTH)
         frame_width_reg = value[lap3_pkg::CFG_WIDTH_W-1:0];
      else frame_height_reg = value;
      next_col = 0;
      next_row = 0;
   endtask

   // one pixel transaction; expectation is the typed one when given
   task automatic send_pixel(input logic [lap3_pkg::PIXEL_W-1:0] px, input bit use_typed,
                             input edge_result_type typed_res);
      edge_result_type predicted;
      bit              has_result;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= px;
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      advance_laplacian(px, has_result, predicted);
      if (use_typed) pending_edges.push_back(typed_res);
      else if (has_result) pending_edges.push_back(predicted);
   endtask

   // mostly full-range gray levels, sometimes only black and white to hit the extremes
   task automatic send_random_pixels(input int count);
      edge_result_type              none;
      bit                           binary;
      logic [lap3_pkg::PIXEL_W-1:0] px;
      none   = '{default: '0};
      binary = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) begin
         if (binary) px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else px = lap3_pkg::PIXEL_W'($urandom_range(0, 255));
         send_pixel(px, 1'b0, none);
         // occasional pause mid-frame until the results catch up
         if ($urandom_range(0, 63) == 0) drain_results();
      end
   endtask

   // new frame geometry, then full frames, a partial frame or a short burst
   task automatic run_random_phase(inout int sent);
      int kind;
      int w_data;
      int h_data;
      int w;
      int h;
      int n;
      kind   = $urandom_range(0, 9);
      w_data = $urandom_range(3, 12);
      h_data = $urandom_range(3, 8);
      case (kind)
         0: w_data = $urandom_range(0, 2);          // saturates up to 3
         1: h_data = $urandom_range(0, 2);          // saturates up to 3
         2: h_data = $urandom_range(4097, 8191);    // saturates at the height limit
         3: w_data = $urandom_range(1025, 8191);    // masked to 11 bits, then saturated to 3..max width
         default: ;
      endcase
      // sometimes only one register changes
      if (kind == 0 || kind == 3 || $urandom_range(0, 4) != 0)
         write_csr(lap3_pkg::REG_IMAGE_WIDTH, lap3_pkg::CSR_DATA_W'(w_data));
      if (kind == 1 || kind == 2 || $urandom_range(0, 4) != 0)
         write_csr(lap3_pkg::REG_IMAGE_HEIGHT, lap3_pkg::CSR_DATA_W'(h_data));
      w = active_width();
      h = active_height();
      if (w > 64) n = $urandom_range(1, 8);
      else if (h > 16) n = $urandom_range(3 * w, 6 * w);
      else if ($urandom_range(0, 2) != 0) n = w * h * $urandom_range(1, 2);
      else n = $urandom_range(1, 2 * w * h);
      send_random_pixels(n);
      sent += n;
   endtask

   // result side: random back-pressure and in-order compare
   initial begin : result_monitor
      edge_result_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_edges.size() == 0) begin
               error_count++;
               $error("result with none expected: edge_value %0d", rsp_bus.edge_value);
            end else begin
               want = pending_edges.pop_front();
               if (rsp_bus.edge_value !== want.edge_value) begin
                  error_count++;
                  $error("edge_value mismatch: expected %0d, actual %0d",
                         want.edge_value, rsp_bus.edge_value);
               end
               if (rsp_bus.row_last !== want.row_last) begin
                  error_count++;
                  $error("row_last mismatch: expected %0b, actual %0b",
                         want.row_last, rsp_bus.row_last);
               end
               if (rsp_bus.frame_last !== want.frame_last) begin
                  error_count++;
                  $error("frame_last mismatch: expected %0b, actual %0b",
                         want.frame_last, rsp_bus.frame_last);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin : stimulus
      stim_row_type    row;
      edge_result_type typed_res;
      int              mode_items;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.pixel    = '0;
      csr_write_enable = 1'b0;
      csr_index        = lap3_pkg::REG_IMAGE_WIDTH;
      csr_data         = '0;
      error_count      = 0;
      reset_laplacian();
      set_idle_mode(0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < $size(DIRECTED); i++) begin
         row = DIRECTED[i];
         typed_res.edge_value = row.edge_value;
         typed_res.row_last   = row.row_last;
         typed_res.frame_last = row.frame_last;
         case (row.kind)
            ROW_CSR:   write_csr(row.csr_reg, row.csr_value);
            ROW_PIXEL: send_pixel(row.pixel, row.typed, typed_res);
            default:   send_random_pixels(int'(row.burst_len));
         endcase
      end

      // random part in three idle modes
      for (int mode = 0; mode < 3; mode++) begin
         set_idle_mode(mode);
         mode_items = 0;
         if (mode == 0) begin
            // widest frame: all ones masks to 2047 and saturates to max width
            write_csr(lap3_pkg::REG_IMAGE_WIDTH, '1);
            write_csr(lap3_pkg::REG_IMAGE_HEIGHT, lap3_pkg::CSR_DATA_W'(3));
            send_random_pixels(12);
         end
         if (mode == 2) begin
            // tallest frame: all ones saturates at the height limit
            write_csr(lap3_pkg::REG_IMAGE_WIDTH, lap3_pkg::CSR_DATA_W'(3));
            write_csr(lap3_pkg::REG_IMAGE_HEIGHT, '1);
            send_random_pixels(30);
         end
         while (mode_items < ITEMS_PER_MODE) run_random_phase(mode_items);
      end

      // wind down: everything back, then a short settle for stray results
      req_bus.valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_edges.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
